@@ src/sbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// sbpa_pkg
// shared types, codes and field widths of the block pool allocator
// ----------------------------------------------------------------------------
package sbpa_pkg;

    // number of pools and fixed field widths
    localparam int POOL_N      = 4;
    localparam int POOL_W      = 2;
    localparam int SIZE_W      = 24;
    localparam int COUNT_W     = 11;
    localparam int BLOCK_W     = 10;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 4;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_BASE  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_BASE = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT      = 4'd8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT    = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_FIT      = 2'd1,
        STAT_BAD_RELEASE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic execute;   // update lists and read the ring
        logic deliver;   // load the output register
    } cmd_t;

endpackage

@@ src/sbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbpa_ctrl
// sequencer for capture, execute and result delivery
// ----------------------------------------------------------------------------
module sbpa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic          cfg_ready,
    output sbpa_pkg::cmd_t cmd
);

    sbpa_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbpa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbpa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sbpa_pkg::ST_EXEC;
                end
            end
            sbpa_pkg::ST_EXEC: begin
                state_next = sbpa_pkg::ST_FINISH;
            end
            sbpa_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = s_tvalid ? sbpa_pkg::ST_EXEC : sbpa_pkg::ST_IDLE;
                end
            end
            default: state_next = sbpa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready    = 1'b0;
        cfg_ready   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            sbpa_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                // register writes only with nothing in flight and no new input
                cfg_ready   = !m_valid_reg && !s_tvalid;
            end
            sbpa_pkg::ST_EXEC: begin
                cmd.execute = 1'b1;
            end
            sbpa_pkg::ST_FINISH: begin
                s_tready    = out_free;
                cmd.deliver = out_free;
                cmd.capture = out_free && s_tvalid;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.deliver) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

@@ src/sbpa_dp.sv @@
// ----------------------------------------------------------------------------
// sbpa_dp
// pool registers, free rings, pool choice and result register
// ----------------------------------------------------------------------------
module sbpa_dp #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sbpa_pkg::cmd_t                      cmd,
    input  logic [sbpa_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                cfg_valid,
    input  logic [sbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sbpa_pkg::SIZE_W-1:0]         cfg_data,
    output logic [sbpa_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int PW         = $clog2(MAX_BLOCKS);
    localparam int CW         = $clog2(MAX_BLOCKS + 1);
    localparam int EW         = (CW > sbpa_pkg::COUNT_W) ? CW : sbpa_pkg::COUNT_W;
    localparam int RING_DEPTH = sbpa_pkg::POOL_N << PW;

    // configuration
    logic [sbpa_pkg::SIZE_W-1:0]  size_reg  [sbpa_pkg::POOL_N];
    logic [sbpa_pkg::COUNT_W-1:0] count_reg [sbpa_pkg::POOL_N];

    // ring pointers; base is the tail left by init, wrote counts writes since
    logic [PW-1:0] head_reg  [sbpa_pkg::POOL_N];
    logic [PW-1:0] tail_reg  [sbpa_pkg::POOL_N];
    logic [PW-1:0] base_reg  [sbpa_pkg::POOL_N];
    logic [CW-1:0] fill_reg  [sbpa_pkg::POOL_N];
    logic [CW-1:0] wrote_reg [sbpa_pkg::POOL_N];
    logic [sbpa_pkg::SIZE_W-1:0] peak_reg;

    logic [sbpa_pkg::BLOCK_W-1:0] ring_mem [RING_DEPTH];
    logic [sbpa_pkg::BLOCK_W-1:0] rd_reg;

    // captured input
    sbpa_pkg::action_t            act_reg;
    logic [sbpa_pkg::SIZE_W-1:0]  req_reg;
    logic [sbpa_pkg::POOL_W-1:0]  rpool_reg;
    logic [sbpa_pkg::BLOCK_W-1:0] rblk_reg;

    // pending result
    sbpa_pkg::status_t            pend_status_reg;
    logic                         pend_found_reg;
    logic                         pend_use_mem_reg;
    logic [sbpa_pkg::POOL_W-1:0]  pend_pool_reg;
    logic [sbpa_pkg::SIZE_W-1:0]  pend_size_reg;
    logic [PW-1:0]                pend_ident_reg;

    // output register
    logic [sbpa_pkg::STATUS_W-1:0] out_status_reg;
    logic [sbpa_pkg::POOL_W-1:0]   out_pool_reg;
    logic [sbpa_pkg::BLOCK_W-1:0]  out_block_reg;
    logic [sbpa_pkg::SIZE_W-1:0]   out_size_reg;
    logic [sbpa_pkg::SIZE_W-1:0]   out_peak_reg;

    logic [CW-1:0]               eff [sbpa_pkg::POOL_N];
    logic [sbpa_pkg::POOL_N-1:0] avail;
    logic                        found;
    logic [sbpa_pkg::POOL_W-1:0] best;
    logic                        rel_ok;
    logic [PW:0]                 head_off;
    logic                        use_mem;
    logic                        mem_we, mem_re;
    logic [PW-1:0]               best_head;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
        ring_next = (i == PW'(MAX_BLOCKS - 1)) ? '0 : i + 1'b1;
    endfunction

    // effective counts and pools able to serve the request
    always_comb begin
        logic [EW-1:0] c;
        for (int p = 0; p < sbpa_pkg::POOL_N; p++) begin
            c        = EW'(count_reg[p]);
            eff[p]   = (c > EW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(c);
            avail[p] = (count_reg[p] != '0) && (fill_reg[p] != '0)
                       && (size_reg[p] >= req_reg);
        end
    end

    // smallest fitting size, lower index on ties
    always_comb begin
        found = 1'b0;
        best  = '0;
        for (int p = 0; p < sbpa_pkg::POOL_N; p++) begin
            if (avail[p] && (!found || size_reg[p] < size_reg[best])) begin
                best  = sbpa_pkg::POOL_W'(p);
                found = 1'b1;
            end
        end
    end

    assign rel_ok = (count_reg[rpool_reg] != '0)
                    && (EW'(rblk_reg) < EW'(eff[rpool_reg]))
                    && (fill_reg[rpool_reg] < eff[rpool_reg]);

    // entries not yet rewritten since init still hold their own position
    assign best_head = head_reg[best];
    always_comb begin
        head_off = {1'b0, best_head} - {1'b0, base_reg[best]};
        if (best_head < base_reg[best]) begin
            head_off = head_off + (PW + 1)'(MAX_BLOCKS);
        end
        use_mem = head_off < (PW + 1)'(wrote_reg[best]);
    end

    assign mem_we = cmd.execute && (act_reg == sbpa_pkg::ACT_RELEASE) && rel_ok;
    assign mem_re = cmd.execute && (act_reg == sbpa_pkg::ACT_ALLOC) && found;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[{rpool_reg, tail_reg[rpool_reg]}] <= rblk_reg;
        end
        if (mem_re) begin
            rd_reg <= ring_mem[{best, best_head}];
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < sbpa_pkg::POOL_N; p++) begin
                size_reg[p]  <= '0;
                count_reg[p] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index < sbpa_pkg::REG_COUNT_BASE) begin
                size_reg[sbpa_pkg::POOL_W'(cfg_index - sbpa_pkg::REG_SIZE_BASE)] <= cfg_data;
            end else if (cfg_index < sbpa_pkg::REG_LIMIT) begin
                count_reg[sbpa_pkg::POOL_W'(cfg_index - sbpa_pkg::REG_COUNT_BASE)] <=
                    cfg_data[sbpa_pkg::COUNT_W-1:0];
            end
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= sbpa_pkg::action_t'(s_tdata[1:0]);
            req_reg   <= s_tdata[25:2];
            rpool_reg <= s_tdata[27:26];
            rblk_reg  <= s_tdata[37:28];
        end
    end

    // list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < sbpa_pkg::POOL_N; p++) begin
                head_reg[p]  <= '0;
                tail_reg[p]  <= '0;
                base_reg[p]  <= '0;
                fill_reg[p]  <= '0;
                wrote_reg[p] <= '0;
            end
            peak_reg <= '0;
        end else if (cmd.execute) begin
            case (act_reg)
                sbpa_pkg::ACT_INIT: begin
                    for (int p = 0; p < sbpa_pkg::POOL_N; p++) begin
                        head_reg[p]  <= '0;
                        tail_reg[p]  <= (eff[p] == CW'(MAX_BLOCKS)) ? '0 : PW'(eff[p]);
                        base_reg[p]  <= (eff[p] == CW'(MAX_BLOCKS)) ? '0 : PW'(eff[p]);
                        fill_reg[p]  <= eff[p];
                        wrote_reg[p] <= '0;
                    end
                end
                sbpa_pkg::ACT_ALLOC: begin
                    if (req_reg > peak_reg) begin
                        peak_reg <= req_reg;
                    end
                    if (found) begin
                        head_reg[best] <= ring_next(best_head);
                        fill_reg[best] <= fill_reg[best] - 1'b1;
                    end
                end
                sbpa_pkg::ACT_RELEASE: begin
                    if (rel_ok) begin
                        tail_reg[rpool_reg] <= ring_next(tail_reg[rpool_reg]);
                        fill_reg[rpool_reg] <= fill_reg[rpool_reg] + 1'b1;
                        if (wrote_reg[rpool_reg] != CW'(MAX_BLOCKS)) begin
                            wrote_reg[rpool_reg] <= wrote_reg[rpool_reg] + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // pending result
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            pend_found_reg   <= (act_reg == sbpa_pkg::ACT_ALLOC) && found;
            pend_use_mem_reg <= use_mem;
            pend_pool_reg    <= best;
            pend_size_reg    <= size_reg[best];
            pend_ident_reg   <= best_head;
            if ((act_reg == sbpa_pkg::ACT_ALLOC) && !found) begin
                pend_status_reg <= sbpa_pkg::STAT_NO_FIT;
            end else if ((act_reg == sbpa_pkg::ACT_RELEASE) && !rel_ok) begin
                pend_status_reg <= sbpa_pkg::STAT_BAD_RELEASE;
            end else begin
                pend_status_reg <= sbpa_pkg::STAT_OK;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            out_status_reg <= pend_status_reg;
            out_peak_reg   <= peak_reg;
            if (pend_found_reg) begin
                out_pool_reg  <= pend_pool_reg;
                out_size_reg  <= pend_size_reg;
                out_block_reg <= pend_use_mem_reg ? rd_reg
                                                  : sbpa_pkg::BLOCK_W'(pend_ident_reg);
            end else begin
                out_pool_reg  <= '0;
                out_size_reg  <= '0;
                out_block_reg <= '0;
            end
        end
    end

    assign m_tdata = {2'b00, out_peak_reg, out_size_reg, out_block_reg,
                      out_pool_reg, out_status_reg};

endmodule

@@ src/size_class_block_pool_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// size_class_block_pool_allocator_unit
// four pools of fixed-size blocks with fifo free lists, best-fit allocation
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            contents
// s_        in         s_tvalid / s_tready  action, request size, release pool/block
// m_        out        m_tvalid / m_tready  status, grant pool/block/size, peak request
// cfg_      in         cfg_valid/cfg_ready  register index and write data
//
// each transaction passes an execute state that picks the pool and
// reads the free ring memory, then a finish state that loads the output register
// init needs no writes to the ring memory, as untouched ring entries read back
// as their own position
// reset is synchronous on aresetn low and empties every list
// a full output register holds the finish cycle until m_tready frees it
//
module size_class_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS = 1024   // ring depth per pool, 2 to 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // action, request_size, release_pool, release_block
    input  logic [sbpa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // status, granted_pool, granted_block, granted_size, largest_request
    output logic [sbpa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // register writes, taken only while no transaction is in flight
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sbpa_pkg::SIZE_W-1:0]       cfg_data
);

    sbpa_pkg::cmd_t cmd;
    logic           cfg_write;

    // a write lands at the next clock edge once the controller is idle and empty
    assign cfg_write = cfg_valid && cfg_ready;

    sbpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    sbpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule
